@@ rtl/core/jeu_pkg.sv @@
// ----------------------------------------------------------------------------
// jeu_pkg
// Shared types and constants for the JSON string unescaper: the group of
// output bytes that one input byte produces, and the character codes.
// ----------------------------------------------------------------------------
package jeu_pkg;

  localparam int unsigned MAX_BYTES = 4;

  // Bytes that one input item yields, in output order, and how many are used.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                cnt;
  } grp_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_F   = 8'h46;

  localparam logic [7:0] CODE_LF   = 8'h0A;
  localparam logic [7:0] CODE_CR   = 8'h0D;
  localparam logic [7:0] CODE_TAB  = 8'h09;

  localparam logic [15:0] HI_SURR_MIN = 16'hD800;
  localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
  localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
  localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;
  localparam logic [15:0] ONE_BYTE_LIM = 16'h0080;
  localparam logic [15:0] TWO_BYTE_LIM = 16'h0800;

  localparam logic [7:0] LEAD4 = 8'b1111_0000;
  localparam logic [7:0] LEAD3 = 8'b1110_0000;
  localparam logic [7:0] LEAD2 = 8'b1100_0000;
  localparam logic [7:0] CONT  = 8'b1000_0000;

  localparam int unsigned HEX_DIGITS = 4;

endpackage

@@ rtl/core/jeu_front.sv @@
// ----------------------------------------------------------------------------
// jeu_front
// Front end: takes one escaped byte per cycle while accept is high, tracks
// escape state and builds the group of unescaped / UTF-8 bytes it produces.
// ----------------------------------------------------------------------------
module jeu_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [7:0]     in_byte,
  input  logic           string_end,
  output logic           wr,
  output jeu_pkg::grp_t  wr_grp
);
  import jeu_pkg::*;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_HEX   = 2'd2
  } mode_t;

  mode_t       mode, mode_next;
  logic [2:0]  digit_count, digit_count_next;
  logic [15:0] hex_accum, hex_accum_next;
  logic        hex_halted, hex_halted_next;
  logic [15:0] high_half, high_half_next;

  logic        copy_en;
  logic [7:0]  copy_byte;
  logic        fin;
  logic        dig_ok;
  logic [3:0]  dig;
  logic [15:0] code;
  logic        is_hi, is_lo;
  logic [15:0] high_off;
  logic [20:0] cp;
  grp_t        grp;

  // Hex digit decode, both letter cases.
  always_comb begin
    dig_ok = 1'b1;
    dig    = 4'd0;
    if (in_byte >= CH_ZERO && in_byte <= CH_NINE) begin
      dig = in_byte[3:0];
    end else if (in_byte >= CH_LC_A && in_byte <= CH_LC_F) begin
      dig = 4'(in_byte - CH_LC_A + 8'd10);
    end else if (in_byte >= CH_UC_A && in_byte <= CH_UC_F) begin
      dig = 4'(in_byte - CH_UC_A + 8'd10);
    end else begin
      dig_ok = 1'b0;
    end
  end

  // Value of the code once this byte is counted; a fresh code starts at zero.
  always_comb begin
    code = hex_accum;
    if (mode == MODE_ESC) begin
      code = 16'd0;
    end else if (mode == MODE_HEX && !hex_halted && dig_ok) begin
      code = {hex_accum[11:0], dig};
    end
  end

  always_comb begin
    mode_next        = mode;
    digit_count_next = digit_count;
    hex_accum_next   = hex_accum;
    hex_halted_next  = hex_halted;
    high_half_next   = high_half;
    copy_en          = 1'b0;
    copy_byte        = in_byte;
    fin              = 1'b0;

    unique case (mode)
      MODE_ESC: begin
        mode_next = MODE_PLAIN;
        unique case (in_byte)
          CH_ZERO: ;
          CH_N: begin
            copy_en   = 1'b1;
            copy_byte = CODE_LF;
          end
          CH_R: begin
            copy_en   = 1'b1;
            copy_byte = CODE_CR;
          end
          CH_T: begin
            copy_en   = 1'b1;
            copy_byte = CODE_TAB;
          end
          CH_U: begin
            mode_next        = MODE_HEX;
            digit_count_next = 3'd0;
            hex_accum_next   = 16'd0;
            hex_halted_next  = 1'b0;
          end
          default: copy_en = 1'b1;
        endcase
      end
      MODE_HEX: begin
        // A non-hex byte freezes the value; its slot still counts.
        if (!hex_halted && dig_ok) begin
          hex_accum_next = {hex_accum[11:0], dig};
        end else begin
          hex_halted_next = 1'b1;
        end
        digit_count_next = digit_count + 3'd1;
        if (digit_count_next >= 3'(HEX_DIGITS)) begin
          fin       = 1'b1;
          mode_next = MODE_PLAIN;
        end
      end
      default: begin
        mode_next = MODE_PLAIN;
        if (in_byte == CH_BSLASH) begin
          mode_next = MODE_ESC;
        end else begin
          copy_en = 1'b1;
        end
      end
    endcase

    // Flush a partial code at the end of the string.
    if (string_end && mode_next == MODE_HEX) begin
      fin = 1'b1;
    end

    if (fin && is_hi) begin
      high_half_next = code;
    end

    if (string_end) begin
      mode_next        = MODE_PLAIN;
      digit_count_next = 3'd0;
      hex_accum_next   = 16'd0;
      hex_halted_next  = 1'b0;
      high_half_next   = 16'd0;
    end
  end

  // UTF-8 encode of the finished code.
  assign is_hi    = code >= HI_SURR_MIN && code <= HI_SURR_MAX;
  assign is_lo    = code >= LO_SURR_MIN && code <= LO_SURR_MAX;
  assign high_off = high_half - HI_SURR_MIN;
  assign cp       = SUPP_BASE + {high_off[10:0], 10'd0} + {11'd0, code[9:0]};

  always_comb begin
    grp = '0;
    if (copy_en) begin
      grp.bytes[0] = copy_byte;
      grp.cnt      = 3'd1;
    end else if (fin) begin
      priority if (is_hi) begin
        grp.cnt = 3'd0;
      end else if (is_lo) begin
        grp.bytes[0] = LEAD4 | {5'd0, cp[20:18]};
        grp.bytes[1] = CONT  | {2'd0, cp[17:12]};
        grp.bytes[2] = CONT  | {2'd0, cp[11:6]};
        grp.bytes[3] = CONT  | {2'd0, cp[5:0]};
        grp.cnt      = 3'd4;
      end else if (code < ONE_BYTE_LIM) begin
        grp.bytes[0] = code[7:0];
        grp.cnt      = 3'd1;
      end else if (code < TWO_BYTE_LIM) begin
        grp.bytes[0] = LEAD2 | {3'd0, code[10:6]};
        grp.bytes[1] = CONT  | {2'd0, code[5:0]};
        grp.cnt      = 3'd2;
      end else begin
        grp.bytes[0] = LEAD3 | {4'd0, code[15:12]};
        grp.bytes[1] = CONT  | {2'd0, code[11:6]};
        grp.bytes[2] = CONT  | {2'd0, code[5:0]};
        grp.cnt      = 3'd3;
      end
    end
  end

  assign wr     = accept && (grp.cnt != 3'd0);
  assign wr_grp = grp;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_PLAIN;
      digit_count <= 3'd0;
      hex_accum   <= 16'd0;
      hex_halted  <= 1'b0;
      high_half   <= 16'd0;
    end else if (accept) begin
      mode        <= mode_next;
      digit_count <= digit_count_next;
      hex_accum   <= hex_accum_next;
      hex_halted  <= hex_halted_next;
      high_half   <= high_half_next;
    end
  end

endmodule

@@ rtl/core/jeu_queue.sv @@
// ----------------------------------------------------------------------------
// jeu_queue
// Short queue of byte groups between the front end and the output stage.
// ----------------------------------------------------------------------------
module jeu_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  jeu_pkg::grp_t  wr_grp,
  input  logic           rd,
  output logic           full,
  output logic           avail,
  output jeu_pkg::grp_t  head
);
  import jeu_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  grp_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr, do_rd;

  assign full  = (count == CW'(DEPTH));
  assign avail = (count != '0);
  assign head  = mem[rd_ptr];
  assign do_wr = wr && !full;
  assign do_rd = rd && avail;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/core/jeu_back.sv @@
// ----------------------------------------------------------------------------
// jeu_back
// Output stage: holds one byte group and hands its bytes out one per pop,
// flagging the last byte of each group.
// ----------------------------------------------------------------------------
module jeu_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           avail,
  input  jeu_pkg::grp_t  head,
  output logic           take,
  input  logic           pop,
  output logic           empty,
  output logic [7:0]     out_byte,
  output logic           run_end
);
  import jeu_pkg::*;

  grp_t       cur;
  logic [1:0] idx;
  logic       cur_valid;
  logic       last;
  logic       adv;

  assign last     = ({1'b0, idx} == (cur.cnt - 3'd1));
  assign adv      = pop && cur_valid;
  assign take     = avail && (!cur_valid || (adv && last));
  assign empty    = !cur_valid;
  assign out_byte = cur.bytes[idx];
  assign run_end  = last;

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (take) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (adv) begin
      if (last) begin
        cur_valid <= 1'b0;
        idx       <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

@@ rtl/core/json_escape_to_utf8_core.sv @@
// ----------------------------------------------------------------------------
// json_escape_to_utf8_core
// JSON string unescaper producing UTF-8 bytes.
// ----------------------------------------------------------------------------
// One escaped byte is taken per cycle while full is low; each byte yields zero
// to four output bytes, the last of them marked with run_end. The front end
// decodes the escape state and builds the whole byte group in the cycle the
// byte is accepted; a QUEUE_DEPTH-entry group queue feeds the output register,
// which hands out one byte per cycle while pop is high. The first byte of a
// group passes through the group queue and then the output register before it
// is on the output ports and can be popped. Sustained input rate is one byte
// per cycle as long as the output side drains one byte per cycle for every
// byte produced; full rises only when the queue holds QUEUE_DEPTH pending
// groups.
module json_escape_to_utf8_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       string_end,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       run_end
);
  import jeu_pkg::*;

  logic accept;
  logic q_wr;
  grp_t q_wr_grp;
  logic q_avail;
  grp_t q_head;
  logic q_take;

  assign accept = push && !full;

  jeu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .in_byte    (in_byte),
    .string_end (string_end),
    .wr         (q_wr),
    .wr_grp     (q_wr_grp)
  );

  jeu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_wr),
    .wr_grp (q_wr_grp),
    .rd     (q_take),
    .full   (full),
    .avail  (q_avail),
    .head   (q_head)
  );

  jeu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .avail    (q_avail),
    .head     (q_head),
    .take     (q_take),
    .pop      (pop),
    .empty    (empty),
    .out_byte (out_byte),
    .run_end  (run_end)
  );

  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !q_wr)
    else $error("group written while queue full");

  a_group_size: assert property (@(posedge clk) disable iff (rst)
    q_wr |-> (q_wr_grp.cnt != 3'd0 && q_wr_grp.cnt <= 3'(MAX_BYTES)))
    else $error("bad group size");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("waiting result lost");

endmodule

@@ tb/unescape_checker.sv @@
// ----------------------------------------------------------------------------
// unescape_checker
// Watches both sides of the JSON unescaper. It decodes every accepted input
// byte with its own copy of the escape state and holds the UTF-8 bytes that
// should come out. It compares each popped byte and its run_end flag with the
// oldest of them and counts every mismatch.
// ----------------------------------------------------------------------------
module unescape_checker
  import jeu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] in_byte,
  input  logic       string_end,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] out_byte,
  input  logic       run_end,
  output int         mismatches,
  output int         bytes_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    ESC_PLAIN,
    ESC_AFTER_BSLASH,
    ESC_IN_CODE
  } esc_mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } utf8_byte_t;

  utf8_byte_t  utf8_due[$];
  logic [7:0]  run_bytes[$];

  esc_mode_e   mode;
  logic [2:0]  slots_used;
  logic [15:0] code_val;
  logic        code_stopped;
  logic [15:0] high_sur;

  initial begin
    mismatches = 0;
    bytes_due  = 0;
  end

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_LC_A && c <= CH_LC_F) return int'(c - CH_LC_A) + 10;
    if (c >= CH_UC_A && c <= CH_UC_F) return int'(c - CH_UC_A) + 10;
    return -1;
  endfunction

  task automatic clear_decoder();
    mode         = ESC_PLAIN;
    slots_used   = '0;
    code_val     = '0;
    code_stopped = 1'b0;
    high_sur     = '0;
  endtask

  // Turn the collected code into UTF-8; a high surrogate only gets stored.
  task automatic encode_code();
    logic [31:0] cp;
    if (code_val >= HI_SURR_MIN && code_val <= HI_SURR_MAX) begin
      high_sur = code_val;
    end else if (code_val >= LO_SURR_MIN && code_val <= LO_SURR_MAX) begin
      // wraps modulo 2^32 when no high half was stored
      cp = 32'(SUPP_BASE) + (32'(high_sur) - 32'(HI_SURR_MIN)) * 32'h400
           + (32'(code_val) - 32'(LO_SURR_MIN));
      run_bytes.push_back(LEAD4 | {5'b0, cp[20:18]});
      run_bytes.push_back(CONT | {2'b0, cp[17:12]});
      run_bytes.push_back(CONT | {2'b0, cp[11:6]});
      run_bytes.push_back(CONT | {2'b0, cp[5:0]});
    end else if (code_val < ONE_BYTE_LIM) begin
      run_bytes.push_back(code_val[7:0]);
    end else if (code_val < TWO_BYTE_LIM) begin
      run_bytes.push_back(LEAD2 | {3'b0, code_val[10:6]});
      run_bytes.push_back(CONT | {2'b0, code_val[5:0]});
    end else begin
      run_bytes.push_back(LEAD3 | {4'b0, code_val[15:12]});
      run_bytes.push_back(CONT | {2'b0, code_val[11:6]});
      run_bytes.push_back(CONT | {2'b0, code_val[5:0]});
    end
  endtask

  task automatic unescape_byte(input logic [7:0] b, input logic last_of_string);
    int nib;
    run_bytes.delete();
    case (mode)
      ESC_AFTER_BSLASH: begin
        mode = ESC_PLAIN;
        case (b)
          CH_ZERO: ;
          CH_N:    run_bytes.push_back(CODE_LF);
          CH_R:    run_bytes.push_back(CODE_CR);
          CH_T:    run_bytes.push_back(CODE_TAB);
          CH_U: begin
            mode         = ESC_IN_CODE;
            slots_used   = '0;
            code_val     = '0;
            code_stopped = 1'b0;
          end
          default: run_bytes.push_back(b);
        endcase
      end
      ESC_IN_CODE: begin
        nib = nibble_of(b);
        // a non-hex byte freezes the value but still uses up its slot
        if (!code_stopped && nib >= 0) code_val = {code_val[11:0], 4'(nib)};
        else code_stopped = 1'b1;
        slots_used = slots_used + 3'd1;
        if (slots_used >= 3'(HEX_DIGITS)) begin
          encode_code();
          mode = ESC_PLAIN;
        end
      end
      default: begin
        if (b == CH_BSLASH) mode = ESC_AFTER_BSLASH;
        else run_bytes.push_back(b);
      end
    endcase
    if (last_of_string) begin
      // flush a partial code; a lone trailing backslash gives nothing
      if (mode == ESC_IN_CODE) encode_code();
      clear_decoder();
    end
    foreach (run_bytes[i])
      utf8_due.push_back('{data: run_bytes[i], last: (i == run_bytes.size() - 1)});
  endtask

  always @(posedge clk) begin
    utf8_byte_t head;
    if (rst) begin
      clear_decoder();
      utf8_due.delete();
    end else begin
      if (pop && !empty) begin
        if (utf8_due.size() == 0) begin
          $error("out_byte %h run_end %b popped with nothing expected", out_byte, run_end);
          mismatches++;
        end else begin
          head = utf8_due.pop_front();
          if (out_byte !== head.data) begin
            $error("out_byte expected %h actual %h", head.data, out_byte);
            mismatches++;
          end
          if (run_end !== head.last) begin
            $error("run_end expected %b actual %b", head.last, run_end);
            mismatches++;
          end
        end
      end
      if (push && !full) unescape_byte(in_byte, string_end);
    end
    bytes_due <= utf8_due.size();
  end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives escaped JSON string bytes into the unescaper: a directed pass over
// the escapes, surrogate pairs and string-end flushes, then random strings
// made mostly of well-formed escapes, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jeu_pkg::*;

  localparam int         RANDOM_BYTES   = 400;
  localparam int         PAUSE_AT       = 200;
  localparam int         CALM_AT        = 340;
  localparam int         DRAIN_CYCLES   = 10;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam logic [7:0] CH_NONHEX      = 8'h67;
  localparam logic [7:0] CH_QUOTE       = 8'h22;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] in_byte;
  logic       string_end;
  logic       empty;
  logic       pop;
  logic [7:0] out_byte;
  logic       run_end;

  int mismatches;
  int bytes_due;
  int bytes_sent;
  int end_odds;
  int stall_left;
  int quiet_cycles;
  bit calm;
  bit drained;

  json_escape_to_utf8_core dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_byte(in_byte),
    .string_end(string_end), .empty(empty), .pop(pop), .out_byte(out_byte),
    .run_end(run_end)
  );

  unescape_checker u_checker (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_byte(in_byte),
    .string_end(string_end), .empty(empty), .pop(pop), .out_byte(out_byte),
    .run_end(run_end), .mismatches(mismatches), .bytes_due(bytes_due)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Output side: pop stays high except for short random stalls.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      pop <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 4);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic end_roll();
    return end_odds != 0 && $urandom_range(1, end_odds) == 1;
  endfunction

  function automatic logic [7:0] hex_digit_char(input logic [3:0] nib, input bit upper);
    if (nib < 4'd10) return CH_ZERO + 8'(nib);
    return (upper ? CH_UC_A : CH_LC_A) + 8'(nib - 4'd10);
  endfunction

  // Hold the byte on the port until the core takes it.
  task automatic put(input logic [7:0] b, input logic last_of_string);
    int gap;
    gap = (!calm && $urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push       <= 1'b1;
    in_byte    <= b;
    string_end <= last_of_string;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic put_code(input logic [15:0] v, input bit upper);
    put(CH_BSLASH, end_roll());
    put(CH_U, end_roll());
    for (int i = 3; i >= 0; i--) put(hex_digit_char(v[i*4 +: 4], upper), end_roll());
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (bytes_due != 0) @(posedge clk);
  endtask

  initial begin
    logic [7:0] esc_pick [5];
    int         bad_slot;
    rst          = 1'b1;
    push         = 1'b0;
    in_byte      = '0;
    string_end   = 1'b0;
    pop          = 1'b0;
    calm         = 1'b0;
    drained      = 1'b0;
    bytes_sent   = 0;
    end_odds     = 0;
    stall_left   = 0;
    quiet_cycles = 0;
    esc_pick     = '{CH_ZERO, CH_N, CH_R, CH_T, CH_QUOTE};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    put(8'h00, 1'b0);
    put(8'hFF, 1'b1);
    put(CH_BSLASH, 1'b0); put(CH_N, 1'b0);
    put(CH_BSLASH, 1'b0); put(CH_R, 1'b0);
    put(CH_BSLASH, 1'b0); put(CH_T, 1'b0);
    put(CH_BSLASH, 1'b0); put(CH_ZERO, 1'b0);
    put(CH_BSLASH, 1'b0); put(CH_BSLASH, 1'b0);
    put_code(16'hD83D, 1'b1);
    put_code(16'hDE00, 1'b0);
    // non-hex digit stops the value, then the string ends inside the code
    put(CH_BSLASH, 1'b0); put(CH_U, 1'b0); put(CH_ZERO + 8'd1, 1'b0);
    put(CH_NONHEX, 1'b0); put(CH_ZERO, 1'b1);
    put(CH_BSLASH, 1'b0); put(CH_U, 1'b1);
    put(CH_BSLASH, 1'b1);

    bytes_sent = 0;
    end_odds   = 24;
    while (bytes_sent < RANDOM_BYTES) begin
      if (!drained && bytes_sent >= PAUSE_AT) begin
        wait_drained();
        drained = 1'b1;
      end
      if (bytes_sent >= CALM_AT) calm = 1'b1;
      case ($urandom_range(0, 9))
        0, 1: put(8'($urandom_range(0, 255)), end_roll());
        2: begin
          put(CH_BSLASH, end_roll());
          if ($urandom_range(0, 1) == 0) put(esc_pick[$urandom_range(0, 4)], end_roll());
          else put(8'($urandom_range(0, 255)), end_roll());
        end
        3: put_code(16'($urandom_range(0, 16'h007F)), $urandom_range(0, 1));
        4: put_code(16'($urandom_range(16'h0080, 16'h07FF)), $urandom_range(0, 1));
        5: put_code(16'($urandom_range(16'h0800, 16'hFFFF)), $urandom_range(0, 1));
        6, 7: begin
          put_code(16'($urandom_range(HI_SURR_MIN, HI_SURR_MAX)), $urandom_range(0, 1));
          put_code(16'($urandom_range(LO_SURR_MIN, LO_SURR_MAX)), $urandom_range(0, 1));
        end
        8: put_code(16'($urandom_range(LO_SURR_MIN, LO_SURR_MAX)), $urandom_range(0, 1));
        default: begin
          // broken code: at least one slot carries a non-hex byte
          bad_slot = $urandom_range(0, 3);
          put(CH_BSLASH, end_roll());
          put(CH_U, end_roll());
          for (int i = 0; i < 4; i++) begin
            if (i == bad_slot)
              put(CH_NONHEX + 8'($urandom_range(0, 19)), end_roll());
            else if ($urandom_range(0, 2) == 0)
              put(8'($urandom_range(0, 255)), end_roll());
            else
              put(hex_digit_char(4'($urandom_range(0, 15)), $urandom_range(0, 1)),
                  end_roll());
          end
        end
      endcase
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
